// ===== hdl/rsq_pkg.sv =====
package rsq_pkg;

    localparam int LEVEL_W = 10;
    localparam int CODE_W  = 2;
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 7;
    localparam int PEND_W  = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // input command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_ENTER  = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_NONE       = 2'd0;
    localparam logic [1:0] KIND_CLASSIFIED = 2'd1;
    localparam logic [1:0] KIND_SORTED     = 2'd2;

    // material codes
    localparam logic [CODE_W-1:0] MAT_BLACK    = 2'd0;
    localparam logic [CODE_W-1:0] MAT_STEEL    = 2'd1;
    localparam logic [CODE_W-1:0] MAT_WHITE    = 2'd2;
    localparam logic [CODE_W-1:0] MAT_ALUMINUM = 2'd3;

    // bucket directions
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // faults
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_BLACK_LOW     = 3'd0;
    localparam logic [2:0] REG_BLACK_HIGH    = 3'd1;
    localparam logic [2:0] REG_STEEL_LOW     = 3'd2;
    localparam logic [2:0] REG_STEEL_HIGH    = 3'd3;
    localparam logic [2:0] REG_WHITE_LOW     = 3'd4;
    localparam logic [2:0] REG_WHITE_HIGH    = 3'd5;
    localparam logic [2:0] REG_ALUMINUM_LOW  = 3'd6;
    localparam logic [2:0] REG_ALUMINUM_HIGH = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] black_low;
        logic [LEVEL_W-1:0] black_high;
        logic [LEVEL_W-1:0] steel_low;
        logic [LEVEL_W-1:0] steel_high;
        logic [LEVEL_W-1:0] white_low;
        logic [LEVEL_W-1:0] white_high;
        logic [LEVEL_W-1:0] aluminum_low;
        logic [LEVEL_W-1:0] aluminum_high;
    } thresholds_t;

    localparam thresholds_t THRESH_RESET = '{
        black_low:     10'd943,
        black_high:    10'd1023,
        steel_low:     10'd151,
        steel_high:    10'd750,
        white_low:     10'd751,
        white_high:    10'd942,
        aluminum_low:  10'd0,
        aluminum_high: 10'd150
    };

endpackage

// ===== hdl/reflectivity_sorter_queue.sv =====
// Reflectivity sorter queue.
// Input stream (s_): one word per event. s_tuser carries the command
// (sample, part enters sensor, part reaches end); s_tdata carries the
// reflectivity sample and the sensor line level.
// Output stream (m_): exactly one word per input word, in order. m_tuser
// carries the result kind; m_tdata carries material, bucket move, fault,
// queue fill and the sorted count of the reported material.
// Config port (cfg_): writes one of the eight window thresholds; always
// ready, to be used only while the stream is idle.
// A word accepted on s_ passes through the input register, then the result
// register, before it appears on m_. Throughput: one word per cycle unless a low
// m_tready holds the result; the event logic, one queue memory access and the
// counter update all sit between these two registers.
// The queue memory has a registered read that prefetches the head entry,
// with a one-entry bypass for a write to the address being fetched.
// Reset clears the queue, the counters, the bucket position and loads the
// default thresholds; no clearing pass is needed.
// When m_tready is low the result is held and one more word is taken into
// the input register; s_tready then drops until the result is taken.
module reflectivity_sorter_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int QUARTER_STEPS = 50
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // sample[9:0], part_present[10], zero[15:11]
    input  logic [1:0]  s_tuser,    // cmd[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // material[1:0], direction[3:2], step_total[10:4],
                                    // fault[12:11], pending_parts[17:13],
                                    // material_total[33:18], zero[39:34]
    output logic [1:0]  m_tuser,    // result_kind[1:0]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [rsq_pkg::STEP_W-1:0] STEP_ONE = rsq_pkg::STEP_W'(QUARTER_STEPS);
    localparam logic [rsq_pkg::STEP_W-1:0] STEP_TWO = rsq_pkg::STEP_W'(2 * QUARTER_STEPS);

    // input register
    logic                        in_valid_reg;
    logic [1:0]                  in_cmd_reg;
    logic [rsq_pkg::LEVEL_W-1:0] in_sample_reg;
    logic                        in_present_reg;

    // block state
    rsq_pkg::thresholds_t        thresh_reg;
    logic [rsq_pkg::LEVEL_W-1:0] min_level_reg, min_level_next;
    logic                        sampling_reg, sampling_next;
    logic [AW-1:0]               read_ptr_reg, read_ptr_next;
    logic [AW-1:0]               write_ptr_reg, write_ptr_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [rsq_pkg::CODE_W-1:0]  bucket_reg, bucket_next;
    logic [rsq_pkg::COUNT_W-1:0] counts_reg [4];
    logic [rsq_pkg::COUNT_W-1:0] counts_next [4];
    logic                        byp_valid_reg;
    logic [rsq_pkg::CODE_W-1:0]  byp_data_reg;

    // result register
    logic                        out_valid_reg;
    logic [1:0]                  kind_reg, kind_next;
    logic [rsq_pkg::CODE_W-1:0]  mat_reg, mat_next;
    logic [1:0]                  dir_reg, dir_next;
    logic [rsq_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [1:0]                  fault_reg, fault_next;
    logic [rsq_pkg::PEND_W-1:0]  pend_reg;
    logic [rsq_pkg::COUNT_W-1:0] total_reg, total_next;

    logic                        advance;
    logic [rsq_pkg::LEVEL_W-1:0] new_min;
    logic [rsq_pkg::CODE_W-1:0]  class_code;
    logic [rsq_pkg::CODE_W-1:0]  ram_rdata;
    logic [rsq_pkg::CODE_W-1:0]  head_code;
    logic [rsq_pkg::CODE_W-1:0]  diff;
    logic [rsq_pkg::COUNT_W-1:0] count_inc;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rsq_pkg::CODE_W-1:0]  wr_data;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign new_min   = (in_sample_reg < min_level_reg) ? in_sample_reg : min_level_reg;
    assign head_code = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign diff      = bucket_reg - head_code;
    assign count_inc = (counts_reg[head_code] == rsq_pkg::COUNT_MAX) ?
                       counts_reg[head_code] : counts_reg[head_code] + 1'b1;

    rsq_classify u_classify (
        .level  (new_min),
        .thresh (thresh_reg),
        .code   (class_code)
    );

    rsq_ram #(
        .WIDTH (rsq_pkg::CODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_code_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (read_ptr_next),
        .rd_data (ram_rdata)
    );

    always_comb begin
        min_level_next = min_level_reg;
        sampling_next  = sampling_reg;
        read_ptr_next  = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        fill_next      = fill_reg;
        bucket_next    = bucket_reg;
        for (int i = 0; i < 4; i++) begin
            counts_next[i] = counts_reg[i];
        end
        wr_en      = 1'b0;
        wr_addr    = write_ptr_reg;
        wr_data    = class_code;
        kind_next  = rsq_pkg::KIND_NONE;
        mat_next   = rsq_pkg::MAT_BLACK;
        dir_next   = rsq_pkg::DIR_NONE;
        step_next  = '0;
        fault_next = rsq_pkg::FAULT_NONE;
        total_next = '0;

        if (advance) begin
            case (in_cmd_reg)
                rsq_pkg::CMD_SAMPLE: begin
                    if (sampling_reg) begin
                        min_level_next = new_min;
                        if (!in_present_reg) begin
                            wr_en         = 1'b1;
                            wr_addr       = (write_ptr_reg == '0) ? PTR_LAST
                                                                  : write_ptr_reg - 1'b1;
                            wr_data       = class_code;
                            sampling_next = 1'b0;
                            kind_next     = rsq_pkg::KIND_CLASSIFIED;
                            mat_next      = class_code;
                            total_next    = counts_reg[class_code];
                        end
                    end
                end
                rsq_pkg::CMD_ENTER: begin
                    if (in_present_reg) begin
                        if (fill_reg >= FILL_FULL) begin
                            fault_next    = rsq_pkg::FAULT_FULL;
                            sampling_next = 1'b0;
                        end else begin
                            min_level_next = rsq_pkg::LEVEL_MAX;
                            wr_en          = 1'b1;
                            wr_addr        = write_ptr_reg;
                            wr_data        = rsq_pkg::MAT_BLACK;
                            write_ptr_next = (write_ptr_reg == PTR_LAST) ? '0
                                                                         : write_ptr_reg + 1'b1;
                            fill_next      = fill_reg + 1'b1;
                            sampling_next  = 1'b1;
                        end
                    end
                end
                rsq_pkg::CMD_END: begin
                    if (in_present_reg) begin
                        if (fill_reg == '0) begin
                            fault_next = rsq_pkg::FAULT_EMPTY;
                        end else begin
                            read_ptr_next = (read_ptr_reg == PTR_LAST) ? '0
                                                                       : read_ptr_reg + 1'b1;
                            fill_next     = fill_reg - 1'b1;
                            case (diff)
                                2'd1: begin
                                    dir_next  = rsq_pkg::DIR_CW;
                                    step_next = STEP_ONE;
                                end
                                2'd2: begin
                                    dir_next  = rsq_pkg::DIR_CW;
                                    step_next = STEP_TWO;
                                end
                                2'd3: begin
                                    dir_next  = rsq_pkg::DIR_CCW;
                                    step_next = STEP_ONE;
                                end
                                default: begin
                                    dir_next  = rsq_pkg::DIR_NONE;
                                    step_next = '0;
                                end
                            endcase
                            bucket_next            = head_code;
                            counts_next[head_code] = count_inc;
                            kind_next              = rsq_pkg::KIND_SORTED;
                            mat_next               = head_code;
                            total_next             = count_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= rsq_pkg::THRESH_RESET;
            min_level_reg <= rsq_pkg::LEVEL_MAX;
            sampling_reg  <= 1'b0;
            read_ptr_reg  <= '0;
            write_ptr_reg <= '0;
            fill_reg      <= '0;
            bucket_reg    <= rsq_pkg::MAT_BLACK;
            for (int i = 0; i < 4; i++) begin
                counts_reg[i] <= '0;
            end
            byp_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_addr)
                    rsq_pkg::REG_BLACK_LOW:     thresh_reg.black_low     <= cfg_data;
                    rsq_pkg::REG_BLACK_HIGH:    thresh_reg.black_high    <= cfg_data;
                    rsq_pkg::REG_STEEL_LOW:     thresh_reg.steel_low     <= cfg_data;
                    rsq_pkg::REG_STEEL_HIGH:    thresh_reg.steel_high    <= cfg_data;
                    rsq_pkg::REG_WHITE_LOW:     thresh_reg.white_low     <= cfg_data;
                    rsq_pkg::REG_WHITE_HIGH:    thresh_reg.white_high    <= cfg_data;
                    rsq_pkg::REG_ALUMINUM_LOW:  thresh_reg.aluminum_low  <= cfg_data;
                    rsq_pkg::REG_ALUMINUM_HIGH: thresh_reg.aluminum_high <= cfg_data;
                    default: begin
                    end
                endcase
            end

            min_level_reg <= min_level_next;
            sampling_reg  <= sampling_next;
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            fill_reg      <= fill_next;
            bucket_reg    <= bucket_next;
            for (int i = 0; i < 4; i++) begin
                counts_reg[i] <= counts_next[i];
            end
            // head prefetch misses a same-cycle write to the fetched entry
            byp_valid_reg <= wr_en && (wr_addr == read_ptr_next);
        end

        if (s_tready) begin
            in_cmd_reg     <= s_tuser;
            in_sample_reg  <= s_tdata[9:0];
            in_present_reg <= s_tdata[10];
        end
        byp_data_reg <= wr_data;
        if (advance) begin
            kind_reg  <= kind_next;
            mat_reg   <= mat_next;
            dir_reg   <= dir_next;
            step_reg  <= step_next;
            fault_reg <= fault_next;
            pend_reg  <= rsq_pkg::PEND_W'(fill_next);
            total_reg <= total_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, total_reg, pend_reg, fault_reg, step_reg, dir_reg, mat_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("queue fill above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == '0 |-> read_ptr_reg == write_ptr_reg)
        else $error("empty queue with unequal pointers");

    a_sort_dequeues: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && kind_next == rsq_pkg::KIND_SORTED
        |=> fill_reg == $past(fill_reg) - 1'b1 && m_tuser == rsq_pkg::KIND_SORTED)
        else $error("sorted result without dequeue");

    a_classify_ends_sampling: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && kind_next == rsq_pkg::KIND_CLASSIFIED |=> !sampling_reg)
        else $error("sampling still active after classification");

    a_full_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && fault_next == rsq_pkg::FAULT_FULL |-> fill_reg == FILL_FULL)
        else $error("full fault with room in queue");

endmodule

// ===== hdl/rsq_ram.sv =====
module rsq_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rsq_classify.sv =====
module rsq_classify (
    input  logic [rsq_pkg::LEVEL_W-1:0] level,
    input  rsq_pkg::thresholds_t        thresh,
    output logic [rsq_pkg::CODE_W-1:0]  code
);

    logic is_white;
    logic is_black;
    logic is_aluminum;
    logic is_steel;

    assign is_white    = (level >= thresh.white_low)    && (level <= thresh.white_high);
    assign is_black    = (level >= thresh.black_low)    && (level <= thresh.black_high);
    assign is_aluminum = (level >= thresh.aluminum_low) && (level <= thresh.aluminum_high);
    assign is_steel    = (level >= thresh.steel_low)    && (level <= thresh.steel_high);

    // priority: white, black, aluminum, steel; no match keeps black
    always_comb begin
        if (is_white) begin
            code = rsq_pkg::MAT_WHITE;
        end else if (is_black) begin
            code = rsq_pkg::MAT_BLACK;
        end else if (is_aluminum) begin
            code = rsq_pkg::MAT_ALUMINUM;
        end else if (is_steel) begin
            code = rsq_pkg::MAT_STEEL;
        end else begin
            code = rsq_pkg::MAT_BLACK;
        end
    end

endmodule
